@@ sv/kdgf_pkg.sv @@
package kdgf_pkg;

    localparam int SPAN_WIDTH    = 20;
    localparam int FRACTION_BITS = 4;

    // Default limits: 8 ms and 1440 ms in fixed point
    localparam logic [SPAN_WIDTH-1:0] SHORT_LIMIT_RESET = SPAN_WIDTH'(8 << FRACTION_BITS);
    localparam logic [SPAN_WIDTH-1:0] LONG_LIMIT_RESET  = SPAN_WIDTH'(1440 << FRACTION_BITS);

    // Configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_SHORT_LIMIT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_LIMIT  = 1'd1;

    // Merge pass kinds
    localparam int PASS_KIND_W = 2;
    localparam logic [PASS_KIND_W-1:0] PASS_SHORT_SPACE = 2'd0;
    localparam logic [PASS_KIND_W-1:0] PASS_SHORT_MARK  = 2'd1;
    localparam logic [PASS_KIND_W-1:0] PASS_LONG_MARK   = 2'd2;
    localparam logic [PASS_KIND_W-1:0] PASS_LONG_GAP    = 2'd3;
    localparam int NUM_PASSES = 4;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    typedef logic [SPAN_WIDTH-1:0] span_t;

    typedef struct packed {
        logic  is_mark;
        span_t span;
        logic  batch_end;
    } in_item_t;

    typedef struct packed {
        logic  out_mark;
        span_t out_span;
        logic  out_final;
    } out_item_t;

    // Interval as it moves between passes, with flags for the current span
    typedef struct packed {
        logic  mark;
        span_t span;
        logic  fin;
        logic  is_short;
        logic  is_long;
    } work_item_t;

    function automatic work_item_t make_item(
        input logic  mark,
        input span_t span,
        input logic  fin,
        input span_t short_limit,
        input span_t long_limit
    );
        work_item_t w;
        w.mark     = mark;
        w.span     = span;
        w.fin      = fin;
        w.is_short = (span < short_limit);
        w.is_long  = (span > long_limit);
        return w;
    endfunction

    function automatic span_t sat_sum3(input span_t a, input span_t b, input span_t c);
        logic [SPAN_WIDTH+1:0] s;
        s = {2'b00, a} + {2'b00, b} + {2'b00, c};
        return (|s[SPAN_WIDTH+1:SPAN_WIDTH]) ? {SPAN_WIDTH{1'b1}} : s[SPAN_WIDTH-1:0];
    endfunction

endpackage

@@ sv/kdgf_front.sv @@
module kdgf_front
    import kdgf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  span_t      short_limit,
    input  span_t      long_limit,
    input  logic       up_valid,
    output logic       up_ready,
    input  in_item_t   up_item,
    output logic       dn_valid,
    input  logic       dn_ready,
    output work_item_t dn_item
);

    // classify on entry, then a small queue toward the passes
    work_item_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_PTR_W:0]     count_reg, count_next;
    logic                    push, pop;

    assign up_ready = (count_reg != (FIFO_PTR_W+1)'(FIFO_DEPTH));
    assign dn_valid = (count_reg != '0);
    assign dn_item  = mem_reg[rd_ptr_reg];
    assign push     = up_valid && up_ready;
    assign pop      = dn_valid && dn_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= make_item(up_item.is_mark, up_item.span, up_item.batch_end,
                                             short_limit, long_limit);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ sv/kdgf_pass.sv @@
module kdgf_pass
    import kdgf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [PASS_KIND_W-1:0] kind,
    input  span_t                  short_limit,
    input  span_t                  long_limit,
    input  logic                   up_valid,
    output logic                   up_ready,
    input  work_item_t             up_item,
    output logic                   dn_valid,
    input  logic                   dn_ready,
    output work_item_t             dn_item
);

    // head and next are held; the incoming beat plays "after"
    work_item_t slot0_reg, slot0_next;
    work_item_t slot1_reg, slot1_next;
    logic [1:0] fill_reg, fill_next;
    logic       flush_reg, flush_next;
    logic       las_long_reg, las_long_next;
    logic       out_valid_reg, out_valid_next;
    work_item_t out_item_reg, out_item_next;

    logic       out_free;
    logic       accept;
    logic       cond;

    assign out_free = !out_valid_reg || dn_ready;
    assign up_ready = !flush_reg && out_free;
    assign accept   = up_valid && up_ready;
    assign dn_valid = out_valid_reg;
    assign dn_item  = out_item_reg;

    always_comb
    begin
        unique case (kind)
            PASS_SHORT_SPACE: cond = !slot1_reg.mark && slot1_reg.is_short;
            PASS_SHORT_MARK:  cond = slot1_reg.mark && slot1_reg.is_short;
            PASS_LONG_MARK:   cond = slot1_reg.mark && slot1_reg.is_long;
            PASS_LONG_GAP:    cond = slot1_reg.mark && las_long_reg && up_item.is_long;
            default:          cond = 1'b0;
        endcase
    end

    always_comb
    begin
        slot0_next     = slot0_reg;
        slot1_next     = slot1_reg;
        fill_next      = fill_reg;
        flush_next     = flush_reg;
        las_long_next  = las_long_reg;
        out_valid_next = out_valid_reg && !dn_ready;
        out_item_next  = out_item_reg;

        if (accept)
        begin
            case (fill_reg)
                2'd0:
                begin
                    slot0_next    = up_item;
                    fill_next     = 2'd1;
                    las_long_next = up_item.is_long;
                end
                2'd1:
                begin
                    slot1_next = up_item;
                    fill_next  = 2'd2;
                end
                default:
                begin
                    if (cond)
                    begin
                        slot0_next.span = sat_sum3(slot0_reg.span, slot1_reg.span, up_item.span);
                        fill_next       = 2'd1;
                        las_long_next   = up_item.is_long;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_item_next  = make_item(slot0_reg.mark, slot0_reg.span, 1'b0,
                                                   short_limit, long_limit);
                        slot0_next     = slot1_reg;
                        slot1_next     = up_item;
                        fill_next      = 2'd2;
                        las_long_next  = slot1_reg.is_long;
                    end
                end
            endcase
            flush_next = up_item.fin;
        end
        else if (flush_reg && out_free)
        begin
            // drain held intervals in order, last one closes the batch
            out_valid_next = 1'b1;
            out_item_next  = make_item(slot0_reg.mark, slot0_reg.span, fill_reg == 2'd1,
                                       short_limit, long_limit);
            slot0_next     = slot1_reg;
            fill_next      = fill_reg - 2'd1;
            flush_next     = (fill_reg != 2'd1);
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg    <= slot0_next;
        slot1_reg    <= slot1_next;
        out_item_reg <= out_item_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            flush_reg     <= 1'b0;
            las_long_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            flush_reg     <= flush_next;
            las_long_reg  <= las_long_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ sv/keying_duration_glitch_filter.sv @@
// Keying interval glitch filter. Each input beat is one on/off keying interval
// (mark flag, duration in ms with FRACTION_BITS fraction bits); results are the
// same intervals after four cascaded merge passes (short space, short mark,
// long mark, long gap), each folding the next two intervals into its head while
// its condition holds. batch_end flushes every pass, and the last result of the
// batch carries out_final. One interval is taken per clock while result_ready
// holds and no pass is draining; the rate is set by the one-beat-per-cycle
// output register of each pass. An interval goes through the queue and, in each
// pass, the held slots and the output register, and it waits in each pass for
// two later intervals or for the batch end. A batch end makes each pass drain
// its held intervals, at most two, during which that pass takes no new
// interval; the 4-deep queue behind the input classifier soaks up the short
// stall. Limits are written through the cfg port; the user must write them
// only while the block is idle, as the block itself does not enforce it.
module keying_duration_glitch_filter
    import kdgf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wen,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  span_t                  cfg_data,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  in_item_t               item,
    output logic                   result_valid,
    input  logic                   result_ready,
    output out_item_t              result
);

    span_t      short_limit_reg;
    span_t      long_limit_reg;

    // link 0 is the queue output, link NUM_PASSES feeds the result port
    logic       link_valid [NUM_PASSES+1];
    logic       link_ready [NUM_PASSES+1];
    work_item_t link_item  [NUM_PASSES+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_limit_reg <= SHORT_LIMIT_RESET;
            long_limit_reg  <= LONG_LIMIT_RESET;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                REG_SHORT_LIMIT: short_limit_reg <= cfg_data;
                REG_LONG_LIMIT:  long_limit_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    // front: classify each beat against the limits and queue it
    kdgf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .short_limit (short_limit_reg),
        .long_limit  (long_limit_reg),
        .up_valid    (item_valid),
        .up_ready    (item_ready),
        .up_item     (item),
        .dn_valid    (link_valid[0]),
        .dn_ready    (link_ready[0]),
        .dn_item     (link_item[0])
    );

    // back: the four merge passes in a chain
    for (genvar g = 0; g < NUM_PASSES; g++)
    begin : g_pass
        kdgf_pass u_pass (
            .clk         (clk),
            .rst_n       (rst_n),
            .kind        (PASS_KIND_W'(g)),
            .short_limit (short_limit_reg),
            .long_limit  (long_limit_reg),
            .up_valid    (link_valid[g]),
            .up_ready    (link_ready[g]),
            .up_item     (link_item[g]),
            .dn_valid    (link_valid[g+1]),
            .dn_ready    (link_ready[g+1]),
            .dn_item     (link_item[g+1])
        );
    end

    assign result_valid         = link_valid[NUM_PASSES];
    assign link_ready[NUM_PASSES] = result_ready;
    assign result.out_mark      = link_item[NUM_PASSES].mark;
    assign result.out_span      = link_item[NUM_PASSES].span;
    assign result.out_final     = link_item[NUM_PASSES].fin;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    import kdgf_pkg::*;

    // One interval as the merge passes hold it
    typedef struct packed {
        logic  mark;
        span_t span;
    } interval_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wen = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_SHORT_LIMIT;
    span_t                  cfg_data = '0;
    logic                   item_valid = 1'b0;
    logic                   item_ready;
    in_item_t               item = '0;
    logic                   result_valid;
    logic                   result_ready = 1'b0;
    out_item_t              result;

    keying_duration_glitch_filter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wen      (cfg_wen),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #2 clk = ~clk;

    // Intervals waiting to be driven, and filtered intervals still owed by the block
    in_item_t  pending_beats[$];
    out_item_t owed_intervals[$];

    // Shadow of the limit registers and of the pass state
    span_t       short_lim = SHORT_LIMIT_RESET;
    span_t       long_lim  = LONG_LIMIT_RESET;
    interval_t   window[NUM_PASSES][3];
    int unsigned window_fill[NUM_PASSES] = '{default: 0};
    span_t       gap_pass_last = '0;   // last absorbed span seen by the long gap pass

    bit idling = 1'b1;                 // cleared for stretches with no gaps at all
    int errors = 0;

    // Gap length: mostly short, now and then long
    function automatic int unsigned draw_gap();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 12)
            return $urandom_range(0, 2);
        else if (r < 18)
            return $urandom_range(3, 8);
        return $urandom_range(15, 40);
    endfunction

    // Run one input interval through the four passes and queue what falls out.
    // Passes are walked one at a time: each pass only sees its own input order,
    // so handling pass s fully before pass s+1 gives the same output order.
    task automatic filter_interval(input in_item_t beat);
        interval_t   stream[$];
        bit          stream_fin[$];
        interval_t   next_stream[$];
        bit          next_fin[$];
        interval_t   head;
        interval_t   nxt;
        interval_t   aft;
        int unsigned f;
        bit          fold;
        logic [SPAN_WIDTH+1:0] total;
        out_item_t   r;

        stream.push_back('{mark: beat.is_mark, span: beat.span});
        stream_fin.push_back(beat.batch_end);
        for (int s = 0; s < NUM_PASSES; s++)
        begin
            next_stream.delete();
            next_fin.delete();
            foreach (stream[k])
            begin
                f = window_fill[s];
                window[s][f] = stream[k];
                f++;
                if (f == 1 && s == PASS_LONG_GAP)
                    gap_pass_last = stream[k].span;
                if (f == 3)
                begin
                    head = window[s][0];
                    nxt  = window[s][1];
                    aft  = window[s][2];
                    case (s)
                        PASS_SHORT_SPACE: fold = !nxt.mark && nxt.span < short_lim;
                        PASS_SHORT_MARK:  fold = nxt.mark && nxt.span < short_lim;
                        PASS_LONG_MARK:   fold = nxt.mark && nxt.span > long_lim;
                        default:          fold = nxt.mark && gap_pass_last > long_lim
                                                 && aft.span > long_lim;
                    endcase
                    if (fold)
                    begin
                        total = {2'b00, head.span} + {2'b00, nxt.span} + {2'b00, aft.span};
                        window[s][0].span = (total > {2'b00, {SPAN_WIDTH{1'b1}}})
                                            ? {SPAN_WIDTH{1'b1}} : total[SPAN_WIDTH-1:0];
                        if (s == PASS_LONG_GAP)
                            gap_pass_last = aft.span;
                        f = 1;
                    end
                    else
                    begin
                        next_stream.push_back(head);
                        next_fin.push_back(1'b0);
                        window[s][0] = nxt;
                        window[s][1] = aft;
                        if (s == PASS_LONG_GAP)
                            gap_pass_last = nxt.span;
                        f = 2;
                    end
                end
                // batch end: drain the window in order, final flag on the last one
                if (stream_fin[k])
                begin
                    for (int j = 0; j < f; j++)
                    begin
                        next_stream.push_back(window[s][j]);
                        next_fin.push_back(j == f - 1);
                    end
                    f = 0;
                end
                window_fill[s] = f;
            end
            stream = next_stream;
            stream_fin = next_fin;
        end
        foreach (stream[k])
        begin
            r.out_mark  = stream[k].mark;
            r.out_span  = stream[k].span;
            r.out_final = stream_fin[k];
            owed_intervals.push_back(r);
        end
    endtask

    // Driver: valid holds with a steady payload until the beat is taken
    int unsigned send_gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item <= '0;
            send_gap = 0;
        end
        else
        begin
            if (item_valid && item_ready)
            begin
                filter_interval(item);
                send_gap = idling ? draw_gap() : 0;
            end
            if (item_valid && !item_ready)
                ;   // hold the beat
            else if (send_gap > 0)
            begin
                send_gap--;
                item_valid <= 1'b0;
            end
            else if (pending_beats.size() > 0)
            begin
                item <= pending_beats.pop_front();
                item_valid <= 1'b1;
            end
            else
                item_valid <= 1'b0;
        end
    end

    // Monitor: random back pressure, every taken result checked against the oldest owed one
    int unsigned stall_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (owed_intervals.size() == 0)
                begin
                    $error("result with nothing owed: mark %0d span %0d final %0d",
                           result.out_mark, result.out_span, result.out_final);
                    errors++;
                end
                else
                begin
                    want = owed_intervals.pop_front();
                    if (result.out_mark !== want.out_mark)
                    begin
                        $error("out_mark: expected %0d, got %0d", want.out_mark, result.out_mark);
                        errors++;
                    end
                    if (result.out_span !== want.out_span)
                    begin
                        $error("out_span: expected %0d, got %0d", want.out_span, result.out_span);
                        errors++;
                    end
                    if (result.out_final !== want.out_final)
                    begin
                        $error("out_final: expected %0d, got %0d",
                               want.out_final, result.out_final);
                        errors++;
                    end
                end
            end
            if (stall_left == 0 && idling && $urandom_range(0, 3) == 0)
                stall_left = draw_gap();
            if (stall_left > 0)
            begin
                stall_left--;
                result_ready <= 1'b0;
            end
            else
                result_ready <= 1'b1;
        end
    end

    task automatic send(input logic mark, input span_t span, input logic last);
        in_item_t b;
        b.is_mark = mark;
        b.span = span;
        b.batch_end = last;
        pending_beats.push_back(b);
    endtask

    // Span biased toward the current limits so that every pass gets to fold
    function automatic span_t pick_span();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return (short_lim > 0) ? span_t'($urandom_range(0, short_lim - 1)) : '0;
        else if (r < 6)
            return (long_lim < {SPAN_WIDTH{1'b1}})
                   ? span_t'($urandom_range(long_lim + 1, {SPAN_WIDTH{1'b1}}))
                   : {SPAN_WIDTH{1'b1}};
        else if (r == 6)
            return span_t'($urandom_range(short_lim, long_lim));
        else if (r == 7)
            return $urandom_range(0, 1) ? {SPAN_WIDTH{1'b1}} : '0;
        return span_t'($urandom());
    endfunction

    // Batches of mostly alternating key down / silence; the phase always ends a batch
    task automatic add_random(input int count);
        logic mark;
        mark = $urandom_range(0, 1);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 4) == 0)
                mark = $urandom_range(0, 1);
            else
                mark = ~mark;
            send(mark, pick_span(), (i == count - 1) || ($urandom_range(0, 5) == 0));
        end
    endtask

    // Block is idle once every batch has flushed and drained; allow the pipe to settle
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_beats.size() != 0 || item_valid || owed_intervals.size() != 0);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_limit(input logic [CFG_INDEX_W-1:0] idx, input span_t value);
        @(posedge clk);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            REG_SHORT_LIMIT: short_lim = value;
            REG_LONG_LIMIT:  long_lim = value;
            default: ;
        endcase
        @(posedge clk);
        cfg_wen <= 1'b0;
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed batches with the reset limits (8 ms / 1440 ms)
        send(1'b1, '0, 1'b1);                                   // lone interval, flushes at once
        send(1'b1, '1, 1'b0);                                   // saturating fold
        send(1'b0, '0, 1'b0);
        send(1'b1, '1, 1'b1);
        send(1'b1, 20'd500, 1'b0);                              // short space folds
        send(1'b0, 20'd50, 1'b0);
        send(1'b1, 20'd400, 1'b0);
        send(1'b0, 20'd2000, 1'b0);
        send(1'b1, 20'd300, 1'b1);
        send(1'b0, 20'd500, 1'b0);                              // short mark folds
        send(1'b1, 20'd60, 1'b0);
        send(1'b0, 20'd700, 1'b0);
        send(1'b1, 20'd300, 1'b1);
        send(1'b0, 20'd300, 1'b0);                              // long mark folds
        send(1'b1, 20'd30000, 1'b0);
        send(1'b0, 20'd400, 1'b0);
        send(1'b1, 20'd300, 1'b1);
        send(1'b0, 20'd30000, 1'b0);                            // long gap, folds twice
        send(1'b1, 20'd400, 1'b0);
        send(1'b0, 20'd30000, 1'b0);
        send(1'b1, 20'd400, 1'b0);
        send(1'b0, 20'd30000, 1'b0);
        send(1'b1, 20'd200, 1'b1);
        add_random(30);
        wait_drained();

        // Lowest limits: nothing is short, nearly everything is long
        write_limit(REG_SHORT_LIMIT, '0);
        write_limit(REG_LONG_LIMIT, '0);
        add_random(30);
        wait_drained();

        // Highest limits, and no idling on either side for this stretch
        idling = 1'b0;
        write_limit(REG_SHORT_LIMIT, '1);
        write_limit(REG_LONG_LIMIT, '1);
        add_random(30);
        wait_drained();
        idling = 1'b1;

        // Random mid-range limits
        repeat (2)
        begin
            write_limit(REG_SHORT_LIMIT, span_t'($urandom_range(16, 400)));
            write_limit(REG_LONG_LIMIT, span_t'($urandom_range(500, 5000)));
            add_random(30);
            wait_drained();
        end

        if (errors == 0)
            $display("[keying_duration_glitch_filter] OK");
        else
            $display("[keying_duration_glitch_filter] ERROR");
        $finish;
    end

    // Watchdog well beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("[keying_duration_glitch_filter] ERROR");
        $finish;
    end

endmodule
